// File: hdl/pss_pkg.sv
// shared types, constants and helpers for the pwm superimpose sequencer
package pss_pkg;

	localparam int PWM_PERIOD  = 1023;
	localparam int PWM_RATE_HZ = 46875;
	localparam int ADC_SLOTS   = 8;

	localparam int REG_W  = 16;
	localparam int RATE_W = 16;
	localparam int LVL_W  = 11;
	localparam int CNT_W  = 32;
	localparam int PROD_W = RATE_W + LVL_W;
	localparam int PER_W  = $clog2(PWM_RATE_HZ + 1);
	localparam int SLOT_W = (ADC_SLOTS > 1) ? $clog2(ADC_SLOTS) : 1;
	localparam int DIV_CNT_W = $clog2(PER_W);

	localparam logic [LVL_W-1:0] PWM_TOP = LVL_W'(PWM_PERIOD + 1);
	localparam logic [REG_W-1:0] HALF16 = REG_W'(32767);
	localparam logic [PER_W-1:0] DIVIDEND = PER_W'(PWM_RATE_HZ);

	typedef enum logic [1:0] {
		REG_LIGHT = 2'd0,
		REG_AMPL  = 2'd1,
		REG_FREQ  = 2'd2,
		REG_OE    = 2'd3
	} reg_idx_t;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	localparam logic [1:0] DIR_IDLE = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_MAIN = 2'd1;
	localparam logic [1:0] MODE_COMP = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [RATE_W-1:0] rate;
		logic [1:0]        direction;
	} pss_in_t;

	typedef struct packed {
		logic             compare_write;
		logic [LVL_W-1:0] compare_value;
		logic             channel_update;
		logic [1:0]       channel_mode;
		logic             adc_start;
		logic             adc_frame_done;
		logic             rate_report_valid;
		logic [LVL_W-1:0] rate_report;
	} pss_out_t;

	typedef struct packed {
		logic [LVL_W-1:0] light_offset;
		logic [LVL_W-1:0] swing;
		logic [PER_W-1:0] mod_period;
		logic             output_enable;
		logic             recalc_pend;
		logic             busy;
	} cfg_state_t;

	typedef struct packed {
		logic [LVL_W-1:0] lo;
		logic [LVL_W-1:0] hi;
		logic [LVL_W-1:0] report;
	} level_t;

	typedef struct packed {
		logic             compare_write;
		logic [LVL_W-1:0] compare_value;
		logic             channel_update;
		logic [1:0]       channel_mode;
		logic             adc_start;
		logic             adc_frame_done;
	} tick_t;

	// floor(x / 65535) for quotients below 65536
	function automatic logic [15:0] div_full16(input logic [31:0] x);
		logic [32:0] t;
		t = {1'b0, x} + {17'b0, x[31:16]} + 33'd1;
		return t[31:16];
	endfunction

endpackage

// File: hdl/pss_cfg.sv
// configuration registers, derived offsets and the modulation period divider
module pss_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [1:0]                    index,
	input  logic [pss_pkg::REG_W-1:0]     wdata,
	input  logic                          recalc_take,
	output pss_pkg::cfg_state_t           cfg
);

	typedef enum logic [1:0] {
		DIV_IDLE = 2'b01,
		DIV_RUN  = 2'b10
	} div_state_t;

	div_state_t                        div_state_q;
	logic [pss_pkg::DIV_CNT_W-1:0]     div_cnt_q;
	logic [pss_pkg::REG_W-1:0]         div_rem_q;
	logic [pss_pkg::PER_W-1:0]         div_quo_q;
	logic [pss_pkg::REG_W-1:0]         div_den_q;
	logic [pss_pkg::REG_W:0]           div_trial;
	logic                              div_ge;
	logic [pss_pkg::REG_W-1:0]         div_rem_next;
	logic [pss_pkg::PER_W-1:0]         div_quo_next;

	logic [pss_pkg::LVL_W-1:0]         light_offset_q;
	logic [pss_pkg::LVL_W-1:0]         swing_q;
	logic [pss_pkg::PER_W-1:0]         mod_period_q;
	logic                              output_enable_q;
	logic                              recalc_pend_q;
	logic                              swing_pend_q;
	logic [pss_pkg::PROD_W-1:0]        swing_prod_q;

	logic [pss_pkg::REG_W-1:0]         cap;
	logic [pss_pkg::LVL_W-1:0]         span;
	logic [pss_pkg::PROD_W-1:0]        light_prod;
	logic [15:0]                       light_quo;
	logic [15:0]                       swing_quo;
	logic                              freq_write;

	assign freq_write = we && (pss_pkg::reg_idx_t'(index) == pss_pkg::REG_FREQ);

	assign cap = (wdata > pss_pkg::HALF16) ? pss_pkg::HALF16 : wdata;
	assign span = pss_pkg::LVL_W'(pss_pkg::PWM_PERIOD) - light_offset_q;
	assign light_prod = pss_pkg::PROD_W'(wdata) * pss_pkg::PROD_W'(pss_pkg::PWM_PERIOD);
	assign light_quo = pss_pkg::div_full16(32'(light_prod));
	assign swing_quo = pss_pkg::div_full16(32'(swing_prod_q));

	// restoring divider, one quotient bit per cycle
	assign div_trial = {div_rem_q, div_quo_q[pss_pkg::PER_W-1]};
	assign div_ge = div_trial >= {1'b0, div_den_q};
	always_comb begin
		if (div_ge) begin
			div_rem_next = pss_pkg::REG_W'(div_trial - {1'b0, div_den_q});
		end else begin
			div_rem_next = div_trial[pss_pkg::REG_W-1:0];
		end
	end
	assign div_quo_next = {div_quo_q[pss_pkg::PER_W-2:0], div_ge};

	always_ff @(posedge clk) begin
		if (freq_write) begin
			div_den_q <= wdata;
			div_rem_q <= '0;
			div_quo_q <= pss_pkg::DIVIDEND;
		end else if (div_state_q == DIV_RUN) begin
			div_rem_q <= div_rem_next;
			div_quo_q <= div_quo_next;
		end
		if (we && (pss_pkg::reg_idx_t'(index) == pss_pkg::REG_AMPL)) begin
			swing_prod_q <= pss_pkg::PROD_W'(cap) * pss_pkg::PROD_W'(span);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_state_q     <= DIV_IDLE;
			div_cnt_q       <= '0;
			light_offset_q  <= '0;
			swing_q         <= '0;
			mod_period_q    <= '0;
			output_enable_q <= 1'b1;
			recalc_pend_q   <= 1'b0;
			swing_pend_q    <= 1'b0;
		end else begin
			if (swing_pend_q) begin
				swing_q      <= swing_quo[pss_pkg::LVL_W-1:0];
				swing_pend_q <= 1'b0;
			end
			if (recalc_take) begin
				recalc_pend_q <= 1'b0;
			end
			if (div_state_q == DIV_RUN) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == pss_pkg::DIV_CNT_W'(pss_pkg::PER_W - 1)) begin
					div_state_q  <= DIV_IDLE;
					mod_period_q <= div_quo_next;
				end
			end
			if (we) begin
				unique case (pss_pkg::reg_idx_t'(index))
					pss_pkg::REG_LIGHT: begin
						light_offset_q <= light_quo[pss_pkg::LVL_W-1:0];
						recalc_pend_q  <= 1'b1;
					end
					pss_pkg::REG_AMPL: begin
						swing_pend_q  <= 1'b1;
						recalc_pend_q <= 1'b1;
					end
					pss_pkg::REG_FREQ: begin
						if (wdata == '0) begin
							mod_period_q <= '0;
							div_state_q  <= DIV_IDLE;
						end else begin
							div_state_q <= DIV_RUN;
							div_cnt_q   <= '0;
						end
					end
					pss_pkg::REG_OE: begin
						output_enable_q <= wdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.light_offset  = light_offset_q;
	assign cfg.swing         = swing_q;
	assign cfg.mod_period    = mod_period_q;
	assign cfg.output_enable = output_enable_q;
	assign cfg.recalc_pend   = recalc_pend_q;
	assign cfg.busy          = (div_state_q == DIV_RUN);

endmodule

// File: hdl/pss_level.sv
// low and high compare levels around the mean, with clamping and light offset
module pss_level (
	input  logic [pss_pkg::PROD_W-1:0] prod,
	input  logic [pss_pkg::LVL_W-1:0]  swing,
	input  logic [pss_pkg::LVL_W-1:0]  light_offset,
	output pss_pkg::level_t            level
);

	logic [pss_pkg::LVL_W-1:0] top;
	logic [15:0]               mean_full;
	logic [pss_pkg::LVL_W-1:0] mean;
	logic [pss_pkg::LVL_W:0]   mean2;
	logic [pss_pkg::LVL_W:0]   mean_plus;
	logic [pss_pkg::LVL_W-1:0] lo;
	logic [pss_pkg::LVL_W-1:0] hi;
	logic [pss_pkg::LVL_W-1:0] lo_f;
	logic [pss_pkg::LVL_W-1:0] hi_f;
	logic [pss_pkg::LVL_W:0]   sum;

	assign top       = pss_pkg::PWM_TOP - light_offset;
	assign mean_full = pss_pkg::div_full16(32'(prod));
	assign mean      = mean_full[pss_pkg::LVL_W-1:0];
	assign mean2     = {mean, 1'b0};
	assign mean_plus = {1'b0, mean} + {1'b0, swing};

	always_comb begin
		priority if (mean < swing) begin
			// swing would go below zero: fold it up against zero
			lo = '0;
			hi = (mean2 > {1'b0, top}) ? top : mean2[pss_pkg::LVL_W-1:0];
		end else if (mean_plus < {1'b0, top}) begin
			lo = mean - swing;
			hi = mean_plus[pss_pkg::LVL_W-1:0];
		end else begin
			// swing would pass full scale: fold it down against the top
			lo = pss_pkg::LVL_W'(mean2 - {1'b0, top});
			hi = top;
		end
	end

	assign lo_f = lo + light_offset;
	assign hi_f = hi + light_offset;
	assign sum  = {1'b0, lo_f} + {1'b0, hi_f};

	assign level.lo     = lo_f;
	assign level.hi     = hi_f;
	assign level.report = sum[pss_pkg::LVL_W:1];

endmodule

// File: hdl/pss_tick.sv
// modulation counter, compare loads, channel mode and adc slot schedule
module pss_tick (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [pss_pkg::PER_W-1:0] mod_period,
	input  logic [pss_pkg::LVL_W-1:0] low_compare,
	input  logic [pss_pkg::LVL_W-1:0] high_compare,
	input  logic                      output_enable,
	input  logic [1:0]                direction,
	output pss_pkg::tick_t            tick
);

	localparam int SPROD_W = pss_pkg::SLOT_W + pss_pkg::PER_W;

	logic [pss_pkg::CNT_W-1:0]  counter_q;
	logic [pss_pkg::SLOT_W-1:0] slot_q;
	logic [SPROD_W-1:0]         slot_prod;
	logic [SPROD_W-1:0]         slot_time;
	logic                       slot_hit;
	logic                       slot_last;
	logic [pss_pkg::CNT_W-1:0]  cnt_next;
	logic                       half_hit;
	logic                       end_hit;

	assign slot_prod = SPROD_W'(slot_q) * SPROD_W'(mod_period);
	assign slot_time = SPROD_W'(slot_prod / pss_pkg::ADC_SLOTS);
	assign slot_hit  = pss_pkg::CNT_W'(slot_time) == counter_q;
	assign slot_last = slot_q == pss_pkg::SLOT_W'(pss_pkg::ADC_SLOTS - 1);

	assign cnt_next = counter_q + 1'b1;
	assign half_hit = cnt_next == pss_pkg::CNT_W'(mod_period >> 1);
	assign end_hit  = !half_hit && (cnt_next == pss_pkg::CNT_W'(mod_period));

	always_comb begin
		tick = '0;
		tick.adc_start      = slot_hit;
		tick.adc_frame_done = slot_hit && slot_last;
		if (half_hit) begin
			tick.compare_write = 1'b1;
			tick.compare_value = high_compare;
		end else if (end_hit) begin
			tick.compare_write = 1'b1;
			tick.compare_value = low_compare;
			// with the output enabled, an unknown direction leaves the channel as it is
			priority if (!output_enable || direction == pss_pkg::DIR_IDLE) begin
				tick.channel_update = 1'b1;
				tick.channel_mode   = pss_pkg::MODE_OFF;
			end else if (direction == pss_pkg::DIR_FWD) begin
				tick.channel_update = 1'b1;
				tick.channel_mode   = pss_pkg::MODE_MAIN;
			end else if (direction == pss_pkg::DIR_REV) begin
				tick.channel_update = 1'b1;
				tick.channel_mode   = pss_pkg::MODE_COMP;
			end else begin
				tick.channel_update = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			slot_q    <= '0;
		end else if (fire) begin
			if (slot_hit) begin
				slot_q <= slot_last ? '0 : slot_q + 1'b1;
			end
			counter_q <= end_hit ? '0 : cnt_next;
		end
	end

endmodule

// File: hdl/pwm_superimpose_sequencer_core.sv
// top level of the pwm superimpose sequencer: input stage, result register, glue
//
//  port group   direction  handshake               word
//  req          in         req_valid / req_ready   pss_in_t (req_type, rate, direction)
//  rsp          out        rsp_valid / rsp_ready   pss_out_t (compare, channel, adc, report)
//  cfg          in         cfg_we, no wait         cfg_index, cfg_data
//
// a word passes from the input register to the result register; one word per cycle while rsp does not stall.
// the input register holds the rate product, the level and tick logic sit before rsp.
// a light or amplitude write holds req_ready low until the input register takes a level recompute pass.
// a nonzero frequency write holds req_ready low while the period divider runs.
// rsp stalls back up into the input register; a new word is taken as soon as it frees.
// reset sets the control and config registers at once; data registers such as rsp_q are not reset; no clearing pass.
module pwm_superimpose_sequencer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  pss_pkg::pss_in_t          req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output pss_pkg::pss_out_t         rsp,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [pss_pkg::REG_W-1:0] cfg_data
);

	pss_pkg::cfg_state_t cfg;
	pss_pkg::level_t     lvl;
	pss_pkg::tick_t      tick;

	logic                         vld_s1;
	logic                         recalc_s1;
	pss_pkg::pss_in_t             req_s1;
	logic [pss_pkg::PROD_W-1:0]   prod_s1;

	logic                         rsp_valid_q;
	pss_pkg::pss_out_t            rsp_q;
	pss_pkg::pss_out_t            rsp_next;

	logic [pss_pkg::LVL_W-1:0]    low_compare_q;
	logic [pss_pkg::LVL_W-1:0]    high_compare_q;
	logic [1:0]                   latched_dir_q;
	logic [pss_pkg::RATE_W-1:0]   latched_rate_q;

	logic                         advance;
	logic                         s1_free;
	logic                         accept;
	logic                         recalc_take;
	logic                         tick_fire;
	logic                         set_s1;
	logic [pss_pkg::RATE_W-1:0]   rate_mux;
	logic [pss_pkg::LVL_W-1:0]    top_now;

	pss_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.we          (cfg_we),
		.index       (cfg_index),
		.wdata       (cfg_data),
		.recalc_take (recalc_take),
		.cfg         (cfg)
	);

	// a recompute pass moves through the input register without an output slot
	assign advance     = vld_s1 && (recalc_s1 || !rsp_valid_q || rsp_ready);
	assign s1_free     = !vld_s1 || advance;
	assign req_ready   = s1_free && !cfg.busy && !cfg.recalc_pend;
	assign accept      = req_valid && req_ready;
	assign recalc_take = s1_free && cfg.recalc_pend;
	assign set_s1      = req_s1.req_type == pss_pkg::REQ_SET;
	assign tick_fire   = advance && !recalc_s1 && !set_s1;

	assign rate_mux = accept ? req.rate : latched_rate_q;
	assign top_now  = pss_pkg::PWM_TOP - cfg.light_offset;

	always_ff @(posedge clk) begin
		if (accept || recalc_take) begin
			req_s1  <= req;
			prod_s1 <= pss_pkg::PROD_W'(rate_mux) * pss_pkg::PROD_W'(top_now);
		end
		if (advance && !recalc_s1) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			recalc_s1      <= 1'b0;
			rsp_valid_q    <= 1'b0;
			low_compare_q  <= '0;
			high_compare_q <= '0;
			latched_dir_q  <= pss_pkg::DIR_IDLE;
			latched_rate_q <= '0;
		end else begin
			if (accept || recalc_take) begin
				vld_s1    <= 1'b1;
				recalc_s1 <= !accept;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (accept && req.req_type == pss_pkg::REQ_SET) begin
				latched_rate_q <= req.rate;
			end
			if (advance && (recalc_s1 || set_s1)) begin
				low_compare_q  <= lvl.lo;
				high_compare_q <= lvl.hi;
			end
			if (advance && !recalc_s1 && set_s1) begin
				latched_dir_q <= req_s1.direction;
			end
			if (advance && !recalc_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	pss_level u_level (
		.prod         (prod_s1),
		.swing        (cfg.swing),
		.light_offset (cfg.light_offset),
		.level        (lvl)
	);

	pss_tick u_tick (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (tick_fire),
		.mod_period    (cfg.mod_period),
		.low_compare   (low_compare_q),
		.high_compare  (high_compare_q),
		.output_enable (cfg.output_enable),
		.direction     (latched_dir_q),
		.tick          (tick)
	);

	always_comb begin
		rsp_next = '0;
		if (set_s1) begin
			rsp_next.rate_report_valid = 1'b1;
			rsp_next.rate_report       = lvl.report;
		end else begin
			rsp_next.compare_write  = tick.compare_write;
			rsp_next.compare_value  = tick.compare_value;
			rsp_next.channel_update = tick.channel_update;
			rsp_next.channel_mode   = tick.channel_mode;
			rsp_next.adc_start      = tick.adc_start;
			rsp_next.adc_frame_done = tick.adc_frame_done;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_word_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !recalc_s1) |=> rsp_valid_q)
		else $error("word left the input register without reaching rsp");

	a_set_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.rate_report_valid) |->
		(!rsp_q.compare_write && !rsp_q.channel_update &&
		 !rsp_q.adc_start && !rsp_q.adc_frame_done))
		else $error("set-rate word carries tick fields");

	a_mode_with_load: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.channel_update) |-> rsp_q.compare_write)
		else $error("channel mode refreshed without a compare load");

	a_recalc_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && recalc_s1 && !rsp_valid_q) |=> !rsp_valid_q)
		else $error("recompute pass produced a result word");

endmodule
